### sv/fcq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, widths and the queue word type of the FIR filter.
// No dependencies; every other file of the block uses it.
package fcq_pkg;

	localparam int TAPS   = 100;
	localparam int DATA_W = 16;
	localparam int CIDX_W = 7;
	localparam int PROD_W = 2 * DATA_W;

	// Index of one tap, and a count that can reach TAPS itself.
	localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int CNT_W = $clog2(TAPS + 1);

	// Exact sum of TAPS products, one spare bit, then the quotient by 2^15.
	localparam int ACC_W = PROD_W + 1 + $clog2(TAPS);
	localparam int FRAC_W = 15;
	localparam int QUO_W = ACC_W - FRAC_W;

	localparam int OUT_MAX = 32767;
	localparam int OUT_MIN = -32767;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Word held in the queue between front and back.
	typedef struct packed {
		logic                     is_sample;
		logic [CIDX_W-1:0]        idx;
		logic signed [DATA_W-1:0] value;
	} fcq_item_t;

endpackage

### sv/fcq_in_if.sv
`timescale 1ns / 1ps
// Input channel of the FIR filter: valid/ready plus one command word.
// Uses fcq_pkg for field widths.
interface fcq_in_if;
	logic                             valid;
	logic                             ready;
	logic                             cmd;
	logic [fcq_pkg::CIDX_W-1:0]       coef_index;
	logic signed [fcq_pkg::DATA_W-1:0] value;

	modport source (output valid, cmd, coef_index, value, input ready);
	modport sink   (input valid, cmd, coef_index, value, output ready);
endinterface

### sv/fcq_out_if.sv
`timescale 1ns / 1ps
// Output channel of the FIR filter: valid/ready plus one filtered word.
// Uses fcq_pkg for field widths.
interface fcq_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [fcq_pkg::DATA_W-1:0] filtered;
	logic                              saturated;

	modport source (output valid, filtered, saturated, input ready);
	modport sink   (input valid, filtered, saturated, output ready);
endinterface

### sv/fcq_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, drops loads to missing slots, and queues
// the rest in a two-entry FIFO for the back end. Depends on fcq_pkg, fcq_in_if.
module fcq_front (
	input  logic               clk,
	input  logic               arst_n,
	fcq_in_if.sink             din,
	output logic               q_valid,
	input  logic               q_ready,
	output fcq_pkg::fcq_item_t q_item
);

	fcq_pkg::fcq_item_t fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       keep;
	logic       push;
	logic       pop;

	assign din.ready = (cnt_q != 2'd2);
	assign accept    = din.valid && din.ready;
	// Keep samples and loads that hit an existing slot.
	assign keep = (din.cmd == fcq_pkg::CMD_SAMPLE) ||
	              (int'(din.coef_index) < fcq_pkg::TAPS);
	assign push = accept && keep;
	assign pop  = q_valid && q_ready;

	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{is_sample: (din.cmd == fcq_pkg::CMD_SAMPLE),
			                      idx:       din.coef_index,
			                      value:     din.value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("front FIFO count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !push) else $error("push into full FIFO");
`endif

endmodule

### sv/fcq_back.sv
`timescale 1ns / 1ps
// Back end: coefficient and sample memories, the shared multiply-accumulate
// walk over all taps, the divide-and-clamp and the output register.
// Depends on fcq_pkg and fcq_out_if.
module fcq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  fcq_pkg::fcq_item_t q_item,
	fcq_out_if.source          dout
);

	localparam int IW = fcq_pkg::IDX_W;
	localparam int CW = fcq_pkg::CNT_W;
	localparam int DW = fcq_pkg::DATA_W;
	localparam int AW = fcq_pkg::ACC_W;
	localparam int QW = fcq_pkg::QUO_W;
	localparam int PW = fcq_pkg::PROD_W;
	localparam int FW = fcq_pkg::FRAC_W;
	localparam logic [IW-1:0] LAST_IDX = IW'(fcq_pkg::TAPS - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(fcq_pkg::TAPS);
	localparam logic signed [QW-1:0] Q_MAX = QW'(fcq_pkg::OUT_MAX);
	localparam logic signed [QW-1:0] Q_MIN = QW'(fcq_pkg::OUT_MIN);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic signed [DW-1:0] coef_mem [fcq_pkg::TAPS];
	logic signed [DW-1:0] hist_mem [fcq_pkg::TAPS];
	logic [fcq_pkg::TAPS-1:0] coef_vld_q;

	logic [1:0]    state_q;
	logic [IW-1:0] k_q;
	logic [IW-1:0] wp_q;
	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	logic                 v_s1;
	logic                 use_s1;
	logic signed [DW-1:0] coef_s1;
	logic signed [DW-1:0] hist_s1;
	logic                 v_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [AW-1:0] acc_q;

	logic                 out_vld_q;
	logic signed [DW-1:0] filt_q;
	logic                 sat_q;

	logic                 pop;
	logic                 issue;
	logic [IW-1:0]        coef_addr;
	logic                 rnd;
	logic signed [QW-1:0] quo_floor;
	logic signed [QW-1:0] quo;
	logic                 out_free;
	logic                 out_load;

	assign q_ready  = (state_q == ST_IDLE);
	assign pop      = q_valid && q_ready;
	assign issue    = (state_q == ST_MAC);
	assign coef_addr = IW'(q_item.idx);
	assign out_free = !out_vld_q || dout.ready;
	assign out_load = (state_q == ST_FIN) && out_free;

	// Truncate toward zero: floor shift, then add one for a negative sum with
	// a nonzero fraction.
	assign quo_floor = acc_q[AW-1:FW];
	assign rnd       = acc_q[AW-1] && (acc_q[FW-1:0] != '0);
	assign quo       = quo_floor + QW'(rnd);

	// Memories: one write port, registered reads.
	always_ff @(posedge clk) begin
		if (pop && !q_item.is_sample)
			coef_mem[coef_addr] <= q_item.value;
		if (pop && q_item.is_sample)
			hist_mem[wp_q] <= q_item.value;
		coef_s1 <= coef_mem[k_q];
		hist_s1 <= hist_mem[rd_ptr_q];
		use_s1  <= coef_vld_q[k_q] && (CW'(k_q) < fill_q);
		prod_s2 <= use_s1 ? PW'(coef_s1 * hist_s1) : '0;
		if (pop && q_item.is_sample)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + {{(AW-PW){prod_s2[PW-1]}}, prod_s2};
		if (out_load) begin
			if (quo > Q_MAX) begin
				filt_q <= DW'(Q_MAX);
				sat_q  <= 1'b1;
			end else if (quo < Q_MIN) begin
				filt_q <= DW'(Q_MIN);
				sat_q  <= 1'b1;
			end else begin
				filt_q <= quo[DW-1:0];
				sat_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			coef_vld_q <= '0;
			k_q        <= '0;
			wp_q       <= '0;
			rd_ptr_q   <= '0;
			fill_q     <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (dout.ready)
				out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop && !q_item.is_sample) begin
						coef_vld_q[coef_addr] <= 1'b1;
					end else if (pop) begin
						// Newest sample goes at wp; walk backward from it.
						rd_ptr_q <= wp_q;
						wp_q     <= (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
						if (fill_q != FULL_CNT)
							fill_q <= fill_q + 1'b1;
						k_q     <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					rd_ptr_q <= (rd_ptr_q == '0) ? LAST_IDX : rd_ptr_q - 1'b1;
					if (k_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign dout.valid     = out_vld_q;
	assign dout.filtered  = filt_q;
	assign dout.saturated = sat_q;

`ifndef SYNTHESIS
	a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1 && !v_s2))
		else $error("MAC pipeline busy while idle");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT) else $error("history fill count above tap count");
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == ST_FIN))
		else $error("result loaded outside finish step");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop) else $error("queue popped while busy");
`endif

endmodule

### sv/fir_convolution_q15_saturating.sv
`timescale 1ns / 1ps
// Top level of the 100-tap direct-form FIR filter with Q15 output clamp.
// Depends on fcq_pkg, fcq_in_if, fcq_out_if, fcq_front and fcq_back.
//
//   port  | dir  | word carried
//   ------+------+------------------------------------------------------
//   din   | in   | cmd, coef_index, value: coefficient load or sample
//   dout  | out  | filtered, saturated: one word per sample
//
// The back end stores a coefficient load directly; a sample is handled by
// the single multiply-accumulate unit that walks one tap per cycle through
// the two memories.
// Reset clears control state and all valid bits; both stores then read as
// zero until written, with no clearing pass.
// A two-word queue lets din keep accepting while the back end works, and
// the output register lets the next sample start while dout stalls.
module fir_convolution_q15_saturating (
	input  logic      clk,
	input  logic      arst_n,
	fcq_in_if.sink    din,
	fcq_out_if.source dout
);

	// Queue handshake between front and back.
	logic               q_valid;
	logic               q_ready;
	fcq_pkg::fcq_item_t q_item;

	// Front: classify words, drop loads to missing slots, queue the rest.
	fcq_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	// Back: store coefficients and samples, accumulate, divide, clamp.
	fcq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.dout    (dout)
	);

endmodule

### test/tb_fir_convolution_q15_saturating.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 100-tap Q15 FIR filter with output clamp.
// Depends on fcq_pkg, fcq_in_if, fcq_out_if and fir_convolution_q15_saturating.
module tb_fir_convolution_q15_saturating;

	localparam int   TAPS       = fcq_pkg::TAPS;
	localparam int   DATA_W     = fcq_pkg::DATA_W;
	localparam int   CIDX_W     = fcq_pkg::CIDX_W;
	localparam int   OUT_MAX    = fcq_pkg::OUT_MAX;
	localparam int   OUT_MIN    = fcq_pkg::OUT_MIN;
	localparam logic CMD_LOAD   = fcq_pkg::CMD_LOAD;
	localparam logic CMD_SAMPLE = fcq_pkg::CMD_SAMPLE;

	// Run shape: directed words first, then random traffic.
	localparam int RANDOM_WORDS  = 1625;
	// Long enough for one sample to walk every tap and leave the pipeline.
	localparam int DRAIN_CYCLES  = TAPS + 40;
	// Long receiver hold-off, started once random traffic is under way.
	localparam int HOLD_START    = 400;
	localparam int HOLD_CYCLES   = 900;
	localparam int MAX_GAP       = 8;
	localparam int MAX_BURST     = 24;

	// One filtered word as the block reports it.
	typedef struct packed {
		logic signed [DATA_W-1:0] filtered;
		logic                     saturated;
	} fir_result_t;

	// Keep a private copy of both stores and predict each filtered word.
	class fir_scoreboard;
		logic signed [DATA_W-1:0] coef_mem [TAPS];
		logic signed [DATA_W-1:0] delay_line [TAPS];
		fir_result_t              filtered_q [$];

		function new();
			foreach (coef_mem[k]) begin
				coef_mem[k]   = '0;
				delay_line[k] = '0;
			end
		endfunction

		// Note one accepted input word; a sample queues its filtered word.
		function void note_input(logic cmd, logic [CIDX_W-1:0] idx,
				logic signed [DATA_W-1:0] value);
			longint      acc;
			longint      quo;
			fir_result_t res;
			if (cmd == CMD_LOAD) begin
				// Drop loads aimed past the last tap.
				if (idx < TAPS)
					coef_mem[idx] = value;
				return;
			end
			for (int k = TAPS - 1; k > 0; k--)
				delay_line[k] = delay_line[k-1];
			delay_line[0] = value;
			acc = 0;
			for (int k = 0; k < TAPS; k++)
				acc += longint'(coef_mem[k]) * longint'(delay_line[k]);
			// Integer division truncates toward zero, as the Q15 scaling needs.
			quo = acc / 32768;
			res.saturated = 1'b0;
			if (quo > OUT_MAX) begin
				quo = OUT_MAX;
				res.saturated = 1'b1;
			end else if (quo < OUT_MIN) begin
				quo = OUT_MIN;
				res.saturated = 1'b1;
			end
			res.filtered = DATA_W'(quo);
			filtered_q.push_back(res);
		endfunction

		// Compare one accepted result with the oldest prediction; empty when equal.
		function string check_output(logic signed [DATA_W-1:0] filtered,
				logic saturated);
			fir_result_t want;
			if (filtered_q.size() == 0)
				return $sformatf("unexpected word filtered=%0d saturated=%0b",
					filtered, saturated);
			want = filtered_q.pop_front();
			if (filtered !== want.filtered || saturated !== want.saturated)
				return $sformatf("filtered=%0d saturated=%0b, want %0d/%0b",
					filtered, saturated, want.filtered, want.saturated);
			return "";
		endfunction

		function int pending();
			return filtered_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	fcq_in_if  din_if ();
	fcq_out_if dout_if ();

	fir_convolution_q15_saturating DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	fir_scoreboard sb = new();
	int            err_count  = 0;
	int            sent_count = 0;
	int            burst_left = 1;
	logic          hold_off;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string what);
		err_count++;
		$display("ERROR @%0t: %s", $time, what);
	endtask

	// Offer one word, wait for the handshake, then maybe open a gap.
	task automatic send_word(input logic cmd, input logic [CIDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] value);
		int gap;
		din_if.valid      <= 1'b1;
		din_if.cmd        <= cmd;
		din_if.coef_index <= idx;
		din_if.value      <= value;
		// Values read right after the edge are the ones the block sampled.
		do @(posedge clk); while (!din_if.ready);
		sb.note_input(cmd, idx, value);
		sent_count++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, MAX_BURST);
			// A zero gap runs straight into the next burst with valid held high.
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
			if (gap > 0) begin
				din_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Full-scale, zero and small values in half the picks, the rest spread over the range.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return '0;
			3: return DATA_W'($signed($urandom_range(0, 64)) - 32);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Rewrite every tap with one pattern, so later samples see a full store.
	task automatic sweep_coefficients();
		int                       pattern;
		logic signed [DATA_W-1:0] v;
		pattern = $urandom_range(0, 3);
		for (int k = 0; k < TAPS; k++) begin
			case (pattern)
				0: v = -16'sd32768;
				1: v = 16'sd32767;
				2: v = (k % 2 == 0) ? 16'sd32767 : -16'sd32768;
				default: v = pick_value();
			endcase
			send_word(CMD_LOAD, CIDX_W'(k), v);
		end
	endtask

	// Receiver: check each accepted word, then pick the next ready level.
	// The stall pattern steps through four styles in turn.
	initial begin : receiver
		int  cycle;
		int  style;
		logic next_ready;
		string msg;
		cycle = 0;
		dout_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (dout_if.valid && dout_if.ready) begin
				msg = sb.check_output(dout_if.filtered, dout_if.saturated);
				if (msg != "")
					report_mismatch(msg);
			end
			cycle++;
			style = (cycle / 256) % 4;
			case (style)
				0: next_ready = 1'b1;
				1: next_ready = $urandom_range(0, 1);
				2: next_ready = (cycle % 4 == 0);
				default: next_ready = ($urandom_range(0, 4) != 0);
			endcase
			dout_if.ready <= next_ready && !hold_off;
		end
	end

	// Hold the receiver off long enough for the queue to fill and stall din.
	initial begin : long_hold
		hold_off <= 1'b0;
		wait (sent_count >= HOLD_START);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Give up if the run stalls.
	initial begin : watchdog
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int counted;
		int roll;
		logic [CIDX_W-1:0] idx;

		arst_n            <= 1'b0;
		din_if.valid      <= 1'b0;
		din_if.cmd        <= CMD_LOAD;
		din_if.coef_index <= '0;
		din_if.value      <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full-scale samples on an empty store, ignored slots,
		// positive and negative clamp, truncation toward zero, last tap.
		send_word(CMD_SAMPLE, '0, 16'sd32767);
		send_word(CMD_SAMPLE, '0, -16'sd32768);
		send_word(CMD_LOAD, 7'd100, -16'sd32768);
		send_word(CMD_LOAD, 7'd127, 16'sd32767);
		send_word(CMD_SAMPLE, '0, 16'sd1);
		send_word(CMD_LOAD, 7'd0, -16'sd32768);
		send_word(CMD_SAMPLE, '0, -16'sd32768);
		send_word(CMD_SAMPLE, '0, 16'sd32767);
		send_word(CMD_LOAD, 7'd1, -16'sd32768);
		send_word(CMD_SAMPLE, '0, -16'sd32768);
		send_word(CMD_SAMPLE, '0, -16'sd32768);
		send_word(CMD_LOAD, 7'd0, 16'sd32767);
		send_word(CMD_LOAD, 7'd1, 16'sd32767);
		send_word(CMD_SAMPLE, '0, -16'sd32768);
		send_word(CMD_LOAD, 7'd0, 16'sd1);
		send_word(CMD_LOAD, 7'd1, 16'sd0);
		send_word(CMD_SAMPLE, 7'd127, -16'sd1);
		send_word(CMD_SAMPLE, 7'd85, 16'sd1);
		send_word(CMD_LOAD, 7'd99, 16'sd32767);
		send_word(CMD_LOAD, 7'd99, -16'sd32768);
		send_word(CMD_SAMPLE, 7'd42, 16'sd0);
		send_word(CMD_SAMPLE, '0, -16'sd32768);

		// Random: mostly samples over a changing store, with occasional
		// full-store rewrites and stray loads past the last tap.
		counted = 0;
		while (counted < RANDOM_WORDS) begin
			roll = $urandom_range(0, 299);
			if (roll == 0) begin
				sweep_coefficients();
				counted += TAPS;
			end else if (roll < 225) begin
				send_word(CMD_SAMPLE, CIDX_W'($urandom), pick_value());
				counted++;
			end else begin
				if ($urandom_range(0, 7) == 0) begin
					idx = CIDX_W'($urandom_range(TAPS, 127));
				end else begin
					idx = CIDX_W'($urandom_range(0, TAPS - 1));
					counted++;
				end
				send_word(CMD_LOAD, idx, pick_value());
			end
		end
		din_if.valid <= 1'b0;

		// Drain, then watch a little longer for stray words.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### filelist.f
sv/fcq_pkg.sv
sv/fcq_in_if.sv
sv/fcq_out_if.sv
sv/fcq_front.sv
sv/fcq_back.sv
sv/fir_convolution_q15_saturating.sv
test/tb_fir_convolution_q15_saturating.sv
